// File: rtl/tvp_pkg.sv
package tvp_pkg;

  // Default field widths of the profiler.
  localparam int SPEED_BITS_DEF = 12;
  localparam int DIST_BITS_DEF  = 24;

  // Width of the configuration register index and of the input tdata bus.
  localparam int CFG_ADDR_BITS = 3;
  localparam int IN_TDATA_BITS = 8;

  // Motion phase of one axis.
  typedef enum logic [1:0] {
    PH_RIDE  = 2'd0,
    PH_BRAKE = 2'd1,
    PH_STOP  = 2'd2
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_TARGET_DISTANCE  = 3'd0,
    REG_TARGET_ANGLE     = 3'd1,
    REG_LIN_CRUISE_SPEED = 3'd2,
    REG_ROT_CRUISE_SPEED = 3'd3,
    REG_LIN_ACCEL        = 3'd4,
    REG_ROT_ACCEL        = 3'd5,
    REG_LIN_END_SPEED    = 3'd6,
    REG_ROT_END_SPEED    = 3'd7
  } cfg_reg_t;

endpackage

// File: rtl/tvp_brake_chk.sv
module tvp_brake_chk import tvp_pkg::*; #(
  parameter int SPEED_BITS = SPEED_BITS_DEF,
  parameter int REST_BITS  = DIST_BITS_DEF + 2
) (
  input  logic [SPEED_BITS-1:0]       speed,
  input  logic [SPEED_BITS-1:0]       end_speed,
  input  logic [SPEED_BITS-1:0]       accel,
  input  logic signed [REST_BITS-1:0] rest,
  output logic                        brake
);

  localparam int SQ_W   = 2 * SPEED_BITS;
  localparam int PROD_W = SPEED_BITS + REST_BITS;
  localparam int CMP_W  = (SQ_W > PROD_W) ? SQ_W : PROD_W;

  logic [SPEED_BITS-1:0] diff;
  logic [SQ_W-1:0]       diff_sq;
  logic [PROD_W-1:0]     stop_dist;
  logic                  rest_none;

  // Speed gap to the end speed and its square.
  assign diff    = (speed > end_speed) ? (speed - end_speed) : (end_speed - speed);
  assign diff_sq = diff * diff;

  // Twice the acceleration times the distance left; only used when rest is positive.
  assign stop_dist = {accel, 1'b0} * rest[REST_BITS-2:0];

  assign rest_none = rest[REST_BITS-1] || (rest == '0);

  // Brake when no distance is left, when acceleration is zero, or when
  // (speed - end)^2 >= 2 * accel * rest.
  assign brake = rest_none || (accel == '0) ||
                 (CMP_W'(diff_sq) >= CMP_W'(stop_dist));

endmodule

// File: rtl/tvp_ramp.sv
module tvp_ramp import tvp_pkg::*; #(
  parameter int SPEED_BITS = SPEED_BITS_DEF
) (
  input  logic [SPEED_BITS-1:0] speed,
  input  logic [SPEED_BITS-1:0] goal,
  input  logic [SPEED_BITS-1:0] accel,
  output logic [SPEED_BITS-1:0] speed_next
);

  logic [SPEED_BITS-1:0] gap_up;
  logic [SPEED_BITS-1:0] gap_down;

  assign gap_up   = goal - speed;
  assign gap_down = speed - goal;

  // Step one acceleration toward the goal and land on it when closer than that.
  always_comb begin
    if (speed < goal) begin
      speed_next = (gap_up <= accel) ? goal : (speed + accel);
    end else if (speed > goal) begin
      speed_next = (gap_down <= accel) ? goal : (speed - accel);
    end else begin
      speed_next = speed;
    end
  end

endmodule

// File: rtl/tvp_lin_axis.sv
module tvp_lin_axis import tvp_pkg::*; #(
  parameter int SPEED_BITS = SPEED_BITS_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  restart,
  input  logic [DIST_BITS-1:0]  target_distance,
  input  logic [SPEED_BITS-1:0] cruise_speed,
  input  logic [SPEED_BITS-1:0] accel,
  input  logic [SPEED_BITS-1:0] end_speed,
  output logic [SPEED_BITS-1:0] speed,
  output phase_t                phase
);

  localparam int TRAV_BITS = DIST_BITS + 1;
  localparam int REST_BITS = DIST_BITS + 2;

  phase_t                phase_r, phase_nxt;
  logic [SPEED_BITS-1:0] speed_r, speed_nxt;
  logic [SPEED_BITS-1:0] goal_r, goal_nxt;
  logic [TRAV_BITS-1:0]  trav_r, trav_nxt;

  phase_t                phase_start, phase_mid;
  logic [SPEED_BITS-1:0] goal_start, goal_mid;
  logic [TRAV_BITS-1:0]  trav_start;
  logic signed [REST_BITS-1:0] rest;
  logic                  brake;
  logic                  stop;
  logic [TRAV_BITS:0]    trav_sum;

  // A restart returns the axis to ride with a cleared distance.
  assign phase_start = restart ? PH_RIDE : phase_r;
  assign goal_start  = restart ? cruise_speed : goal_r;
  assign trav_start  = restart ? '0 : trav_r;

  assign rest = $signed({2'b00, target_distance}) - $signed({1'b0, trav_start});

  tvp_brake_chk #(
    .SPEED_BITS (SPEED_BITS),
    .REST_BITS  (REST_BITS)
  ) u_brake_chk (
    .speed     (speed_r),
    .end_speed (end_speed),
    .accel     (accel),
    .rest      (rest),
    .brake     (brake)
  );

  // Phase transitions: ride to braking, then to stop on distance reached or zero speed.
  always_comb begin
    phase_mid = phase_start;
    goal_mid  = goal_start;
    if ((phase_start == PH_RIDE) && brake) begin
      phase_mid = PH_BRAKE;
      goal_mid  = end_speed;
    end
    phase_nxt = phase_mid;
    goal_nxt  = goal_mid;
    if (stop) begin
      phase_nxt = PH_STOP;
      goal_nxt  = end_speed;
    end
  end

  assign stop = (trav_start >= {1'b0, target_distance}) ||
                ((phase_mid == PH_BRAKE) && (speed_r == '0));

  tvp_ramp #(
    .SPEED_BITS (SPEED_BITS)
  ) u_ramp (
    .speed      (speed_r),
    .goal       (goal_nxt),
    .accel      (accel),
    .speed_next (speed_nxt)
  );

  // Travelled distance saturates at its maximum.
  assign trav_sum = {1'b0, trav_start} + (TRAV_BITS + 1)'(speed_nxt);
  assign trav_nxt = trav_sum[TRAV_BITS] ? {TRAV_BITS{1'b1}} : trav_sum[TRAV_BITS-1:0];

  // Axis state, advanced once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STOP;
      speed_r <= '0;
      goal_r  <= '0;
      trav_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      speed_r <= speed_nxt;
      goal_r  <= goal_nxt;
      trav_r  <= trav_nxt;
    end
  end

  assign speed = speed_r;
  assign phase = phase_r;

endmodule

// File: rtl/tvp_rot_axis.sv
module tvp_rot_axis import tvp_pkg::*; #(
  parameter int SPEED_BITS = SPEED_BITS_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        restart,
  input  logic signed [DIST_BITS-1:0] target_angle,
  input  logic [SPEED_BITS-1:0]       cruise_speed,
  input  logic [SPEED_BITS-1:0]       accel,
  input  logic [SPEED_BITS-1:0]       end_speed,
  output logic [SPEED_BITS-1:0]       speed,
  output phase_t                      phase
);

  localparam int TRAV_BITS = DIST_BITS + 2;
  localparam int REST_BITS = DIST_BITS + 3;

  phase_t                       phase_r, phase_nxt;
  logic [SPEED_BITS-1:0]        speed_r, speed_nxt;
  logic [SPEED_BITS-1:0]        goal_r, goal_nxt;
  logic signed [TRAV_BITS-1:0]  trav_r, trav_nxt;

  phase_t                       phase_start, phase_mid;
  logic [SPEED_BITS-1:0]        goal_start;
  logic signed [TRAV_BITS-1:0]  trav_start;
  logic [DIST_BITS-1:0]         ang_abs;
  logic [TRAV_BITS-1:0]         trav_abs;
  logic                         ang_pos;
  logic signed [REST_BITS-1:0]  rest;
  logic                         brake;
  logic signed [TRAV_BITS:0]    trav_sum;

  // A restart returns the axis to ride with a cleared rotation count.
  assign phase_start = restart ? PH_RIDE : phase_r;
  assign goal_start  = restart ? cruise_speed : goal_r;
  assign trav_start  = restart ? '0 : trav_r;

  // Magnitudes of the target angle and of the rotation so far.
  assign ang_abs  = target_angle[DIST_BITS-1] ? (~target_angle + 1'b1) : target_angle;
  assign trav_abs = trav_start[TRAV_BITS-1] ? (~trav_start + 1'b1) : trav_start;
  assign ang_pos  = !target_angle[DIST_BITS-1] && (target_angle != '0);

  assign rest = $signed({3'b000, ang_abs}) - $signed({1'b0, trav_abs});

  tvp_brake_chk #(
    .SPEED_BITS (SPEED_BITS),
    .REST_BITS  (REST_BITS)
  ) u_brake_chk (
    .speed     (speed_r),
    .end_speed (end_speed),
    .accel     (accel),
    .rest      (rest),
    .brake     (brake)
  );

  // Phase transitions: ride to braking, then to stop once braking at zero speed.
  always_comb begin
    phase_mid = phase_start;
    goal_nxt  = goal_start;
    if ((phase_start == PH_RIDE) && brake) begin
      phase_mid = PH_BRAKE;
      goal_nxt  = end_speed;
    end
    phase_nxt = phase_mid;
    if ((phase_mid == PH_BRAKE) && (speed_r == '0)) begin
      phase_nxt = PH_STOP;
      goal_nxt  = end_speed;
    end
  end

  tvp_ramp #(
    .SPEED_BITS (SPEED_BITS)
  ) u_ramp (
    .speed      (speed_r),
    .goal       (goal_nxt),
    .accel      (accel),
    .speed_next (speed_nxt)
  );

  // Count up for a positive target, down otherwise, holding at the signed limits.
  assign trav_sum = ang_pos ?
                    ({trav_start[TRAV_BITS-1], trav_start} + $signed({1'b0, (TRAV_BITS)'(speed_nxt)})) :
                    ({trav_start[TRAV_BITS-1], trav_start} - $signed({1'b0, (TRAV_BITS)'(speed_nxt)}));

  always_comb begin
    if (trav_sum[TRAV_BITS] != trav_sum[TRAV_BITS-1]) begin
      trav_nxt = trav_sum[TRAV_BITS] ? {1'b1, {(TRAV_BITS-1){1'b0}}}
                                     : {1'b0, {(TRAV_BITS-1){1'b1}}};
    end else begin
      trav_nxt = trav_sum[TRAV_BITS-1:0];
    end
  end

  // Axis state, advanced once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STOP;
      speed_r <= '0;
      goal_r  <= '0;
      trav_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      speed_r <= speed_nxt;
      goal_r  <= goal_nxt;
      trav_r  <= trav_nxt;
    end
  end

  assign speed = speed_r;
  assign phase = phase_r;

endmodule

// File: rtl/trapezoid_velocity_profiler_core.sv
// A result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the axis state registers double as the result
// register, so a new item is taken whenever the result is empty or being taken.
// Reset (synchronous, active low): both axes stopped at zero speed and distance,
// accelerations 1, all other configuration registers 0, no result pending.
module trapezoid_velocity_profiler_core import tvp_pkg::*; #(
  parameter int SPEED_BITS = SPEED_BITS_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [((DIST_BITS > SPEED_BITS) ? DIST_BITS : SPEED_BITS)-1:0] cfg_data,
  // Input item channel.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_BITS-1:0] in_tdata,  // [0] restart, rest unused
  // Result item channel.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // From bit 0: lin_speed_out, rot_speed_out, lin_phase_out, rot_phase_out, zero fill
  output logic [((2*SPEED_BITS+4+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_BITS = ((2 * SPEED_BITS + 4 + 7) / 8) * 8;
  localparam int PAY_BITS = 2 * SPEED_BITS + 4;

  logic [DIST_BITS-1:0]        target_distance_r;
  logic signed [DIST_BITS-1:0] target_angle_r;
  logic [SPEED_BITS-1:0]       lin_cruise_r, rot_cruise_r;
  logic [SPEED_BITS-1:0]       lin_accel_r, rot_accel_r;
  logic [SPEED_BITS-1:0]       lin_end_r, rot_end_r;

  logic                        out_valid_r, out_valid_nxt;
  logic                        accept;
  logic                        restart;
  logic [SPEED_BITS-1:0]       lin_speed, rot_speed;
  phase_t                      lin_phase, rot_phase;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_distance_r <= '0;
      target_angle_r    <= '0;
      lin_cruise_r      <= '0;
      rot_cruise_r      <= '0;
      lin_accel_r       <= SPEED_BITS'(1);
      rot_accel_r       <= SPEED_BITS'(1);
      lin_end_r         <= '0;
      rot_end_r         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_TARGET_DISTANCE:  target_distance_r <= cfg_data[DIST_BITS-1:0];
        REG_TARGET_ANGLE:     target_angle_r    <= cfg_data[DIST_BITS-1:0];
        REG_LIN_CRUISE_SPEED: lin_cruise_r      <= cfg_data[SPEED_BITS-1:0];
        REG_ROT_CRUISE_SPEED: rot_cruise_r      <= cfg_data[SPEED_BITS-1:0];
        REG_LIN_ACCEL:        lin_accel_r       <= cfg_data[SPEED_BITS-1:0];
        REG_ROT_ACCEL:        rot_accel_r       <= cfg_data[SPEED_BITS-1:0];
        REG_LIN_END_SPEED:    lin_end_r         <= cfg_data[SPEED_BITS-1:0];
        REG_ROT_END_SPEED:    rot_end_r         <= cfg_data[SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: take an item when the result slot is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign restart   = in_tdata[0];

  tvp_lin_axis #(
    .SPEED_BITS (SPEED_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_lin_axis (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (accept),
    .restart         (restart),
    .target_distance (target_distance_r),
    .cruise_speed    (lin_cruise_r),
    .accel           (lin_accel_r),
    .end_speed       (lin_end_r),
    .speed           (lin_speed),
    .phase           (lin_phase)
  );

  tvp_rot_axis #(
    .SPEED_BITS (SPEED_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_rot_axis (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .restart      (restart),
    .target_angle (target_angle_r),
    .cruise_speed (rot_cruise_r),
    .accel        (rot_accel_r),
    .end_speed    (rot_end_r),
    .speed        (rot_speed),
    .phase        (rot_phase)
  );

  // Result valid flag; the payload is the axis state itself.
  assign out_valid_nxt = accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'({rot_phase, lin_phase, rot_speed, lin_speed});

  // An accepted item always yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("result missing after accepted item");

  // Axis state only moves when an item is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(out_tdata[PAY_BITS-1:0]))
    else $error("axis state changed without an item");

  // A stopped linear axis stays stopped until a restart.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !restart && (lin_phase == PH_STOP)) |=> (lin_phase == PH_STOP))
    else $error("linear axis left stop without restart");

  // A stopped rotational axis stays stopped until a restart.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !restart && (rot_phase == PH_STOP)) |=> (rot_phase == PH_STOP))
    else $error("rotational axis left stop without restart");

endmodule
